// File: src/csl_pkg.sv
// Shared types and constants for the cache set LRU write-back controller.
package csl_pkg;

   // Default configuration of the set.
   localparam int WAYS_DEF     = 4;
   localparam int TAG_BITS_DEF = 20;

   // Fixed widths of the request and response ports.
   localparam int TAG_PORT_W = 20;
   localparam int WAY_PORT_W = 2;
   localparam int CNT_W      = 32;

   // Access kinds carried on req_op.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Lookup chain passed from one way cell to the next.
   typedef struct packed {
      logic match_seen;    // a lower way already holds the tag
      logic invalid_seen;  // a lower way is already free
   } csl_look_type;

   // Broadcast control from the top level to every way cell.
   typedef struct packed {
      logic update;        // an access is being resolved this cycle
      logic hit;           // some valid way holds the tag
      logic full;          // no way is free
      logic write;         // the access is a write
   } csl_ctrl_type;

endpackage

// File: src/csl_sat_counter.sv
// Saturating event counter for the access statistics.
module csl_sat_counter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       count_en,
   output logic [csl_pkg::CNT_W-1:0]  value
);
   import csl_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Step by one unless the counter already sits at its maximum.
   always_comb begin
      count_in = count_ff;
      if (count_en && (count_ff != {CNT_W{1'b1}})) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign value = count_ff;

endmodule

// File: src/csl_way_cell.sv
// One way of the set: tag, valid, dirty and recency rank, with its lookup stage.
module csl_way_cell #(
   parameter int WAYS     = csl_pkg::WAYS_DEF,
   parameter int TAG_BITS = csl_pkg::TAG_BITS_DEF,
   parameter int INDEX    = 0,
   parameter int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TAG_BITS-1:0]    req_tag,
   input  csl_pkg::csl_ctrl_type  ctrl,
   input  logic [RANK_W-1:0]      sel_rank,
   input  csl_pkg::csl_look_type  look_in,
   output csl_pkg::csl_look_type  look_out,
   output logic                   sel,
   output logic [RANK_W-1:0]      rank,
   output logic [TAG_BITS-1:0]    tag,
   output logic                   dirty
);
   import csl_pkg::*;

   localparam logic [RANK_W-1:0] RANK_MRU   = RANK_W'(WAYS - 1);
   localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(INDEX);

   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   logic                valid_ff;
   logic                valid_in;
   logic                dirty_ff;
   logic                dirty_in;
   logic [RANK_W-1:0]   rank_ff;
   logic [RANK_W-1:0]   rank_in;
   logic                match;

   // Tag compare and hand-on of the lookup chain to the next way.
   assign match                 = valid_ff && (tag_ff == req_tag);
   assign look_out.match_seen   = look_in.match_seen || match;
   assign look_out.invalid_seen = look_in.invalid_seen || !valid_ff;

   // This way serves the access: first matching way on a hit, otherwise the
   // first free way, otherwise the least recent way.
   always_comb begin
      if (ctrl.hit) begin
         sel = match && !look_in.match_seen;
      end else if (ctrl.full) begin
         sel = (rank_ff == '0);
      end else begin
         sel = !valid_ff && !look_in.invalid_seen;
      end
   end

   // Next state of the way when the access is resolved.
   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      rank_in  = rank_ff;
      if (ctrl.update) begin
         if (sel) begin
            rank_in  = RANK_MRU;
            valid_in = 1'b1;
            if (!ctrl.hit) begin
               tag_in   = req_tag;
               dirty_in = (ctrl.write == OP_WRITE);
            end else begin
               dirty_in = dirty_ff || (ctrl.write == OP_WRITE);
            end
         end else if (rank_ff > sel_rank) begin
            rank_in = rank_ff - RANK_W'(1);
         end
      end
   end

   // Tag storage carries no reset; it is only read behind the valid bit.
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         rank_ff  <= RANK_RESET;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         rank_ff  <= rank_in;
      end
   end

   assign rank  = rank_ff;
   assign tag   = tag_ff;
   assign dirty = dirty_ff;

endmodule

// File: src/cache_set_lru_writeback_core.sv
// Top level of the cache set controller with LRU replacement and write-back.
//
// Usage:
//   Requests enter on the req_ channel: an access (req_op, req_tag) is taken
//   at a rising edge where start is high and busy is low. busy then stays high
//   for one cycle while the row of way cells compares the tag, picks the way
//   (hit way, first free way, or least recent way) and updates tags, dirty
//   bits and recency ranks.
//   The result appears on the rsp_ ports for exactly one cycle, marked by
//   rsp_strobe, after the request beat has passed through the request register
//   and busy flag and then the response registers. The receiver cannot hold it
//   off; the result is taken at the edge that ends that cycle. A new access is
//   refused while busy is high, since the state update from one pass through
//   the way-cell chain must land before the next lookup.
//   The rsp_*_count ports show saturating running totals, including the
//   access being reported.
//   Reset (synchronous, active high) empties every way, clears all counters,
//   sets the recency order to way index order and drops any pending beat.
module cache_set_lru_writeback_core #(
   parameter int WAYS     = csl_pkg::WAYS_DEF,
   parameter int TAG_BITS = csl_pkg::TAG_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [csl_pkg::TAG_PORT_W-1:0]  req_tag,
   output logic                            rsp_strobe,
   output logic                            rsp_hit,
   output logic [csl_pkg::WAY_PORT_W-1:0]  rsp_way,
   output logic                            rsp_fill,
   output logic                            rsp_writeback,
   output logic [csl_pkg::TAG_PORT_W-1:0]  rsp_victim_tag,
   output logic [csl_pkg::CNT_W-1:0]       rsp_access_count,
   output logic [csl_pkg::CNT_W-1:0]       rsp_hit_count,
   output logic [csl_pkg::CNT_W-1:0]       rsp_miss_count,
   output logic [csl_pkg::CNT_W-1:0]       rsp_writeback_count
);
   import csl_pkg::*;

   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

   // Request register and access-in-progress flag.
   logic                busy_ff;
   logic                busy_in;
   logic                op_ff;
   logic                op_in;
   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;

   // Response registers.
   logic                  strobe_ff;
   logic                  hit_ff;
   logic                  hit_in;
   logic [WAY_PORT_W-1:0] way_ff;
   logic [WAY_PORT_W-1:0] way_in;
   logic                  wb_ff;
   logic                  wb_in;
   logic [TAG_PORT_W-1:0] vtag_ff;
   logic [TAG_PORT_W-1:0] vtag_in;

   // Way cell chain.
   csl_look_type        look [WAYS+1];
   csl_ctrl_type        ctrl;
   logic [WAYS-1:0]     sel_vec;
   logic [WAYS-1:0]     mru_vec;
   logic [RANK_W-1:0]   rank_w  [WAYS];
   logic [TAG_BITS-1:0] tag_w   [WAYS];
   logic [WAYS-1:0]     dirty_vec;
   logic [RANK_W-1:0]   sel_rank;
   logic [WAY_W-1:0]    sel_way;
   logic [TAG_BITS-1:0] sel_tag;
   logic                sel_dirty;
   logic                access_wb;

   assign busy = busy_ff;

   // Capture the request beat; the lookup runs in the following cycle.
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      tag_in  = tag_ff;
      if (busy_ff) begin
         busy_in = 1'b0;
      end else if (start) begin
         busy_in = 1'b1;
         op_in   = req_op;
         tag_in  = TAG_BITS'(req_tag);
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Broadcast of the chain outcome back to the cells.
   assign look[0].match_seen   = 1'b0;
   assign look[0].invalid_seen = 1'b0;
   assign ctrl.update = busy_ff;
   assign ctrl.hit    = look[WAYS].match_seen;
   assign ctrl.full   = !look[WAYS].invalid_seen;
   assign ctrl.write  = op_ff;

   // The row of way cells.
   for (genvar i = 0; i < WAYS; i++) begin : g_way
      csl_way_cell #(
         .WAYS     (WAYS),
         .TAG_BITS (TAG_BITS),
         .INDEX    (i),
         .RANK_W   (RANK_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .req_tag  (tag_ff),
         .ctrl     (ctrl),
         .sel_rank (sel_rank),
         .look_in  (look[i]),
         .look_out (look[i+1]),
         .sel      (sel_vec[i]),
         .rank     (rank_w[i]),
         .tag      (tag_w[i]),
         .dirty    (dirty_vec[i])
      );
      assign mru_vec[i] = (rank_w[i] == RANK_W'(WAYS - 1));
   end

   // Gather rank, index, tag and dirty bit of the single selected way.
   always_comb begin
      sel_rank  = '0;
      sel_way   = '0;
      sel_tag   = '0;
      sel_dirty = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if (sel_vec[i]) begin
            sel_rank  = sel_rank | rank_w[i];
            sel_way   = sel_way | WAY_W'(i);
            sel_tag   = sel_tag | tag_w[i];
            sel_dirty = sel_dirty | dirty_vec[i];
         end
      end
   end

   // A dirty victim is written back only when a miss finds the set full.
   assign access_wb = !ctrl.hit && ctrl.full && sel_dirty;

   always_comb begin
      hit_in  = hit_ff;
      way_in  = way_ff;
      wb_in   = wb_ff;
      vtag_in = vtag_ff;
      if (busy_ff) begin
         hit_in  = ctrl.hit;
         way_in  = WAY_PORT_W'(sel_way);
         wb_in   = access_wb;
         vtag_in = access_wb ? TAG_PORT_W'(sel_tag) : '0;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      way_ff  <= way_in;
      wb_ff   <= wb_in;
      vtag_ff <= vtag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= busy_ff;
      end
   end

   // Running statistics, updated as the access is resolved.
   csl_sat_counter u_access_cnt (
      .clock    (clock),
      .reset    (reset),
      .count_en (busy_ff),
      .value    (rsp_access_count)
   );

   csl_sat_counter u_hit_cnt (
      .clock    (clock),
      .reset    (reset),
      .count_en (busy_ff && ctrl.hit),
      .value    (rsp_hit_count)
   );

   csl_sat_counter u_miss_cnt (
      .clock    (clock),
      .reset    (reset),
      .count_en (busy_ff && !ctrl.hit),
      .value    (rsp_miss_count)
   );

   csl_sat_counter u_wb_cnt (
      .clock    (clock),
      .reset    (reset),
      .count_en (busy_ff && access_wb),
      .value    (rsp_writeback_count)
   );

   assign rsp_strobe     = strobe_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_way        = way_ff;
   assign rsp_fill       = !hit_ff;
   assign rsp_writeback  = wb_ff;
   assign rsp_victim_tag = vtag_ff;

`ifndef SYNTHESIS
   // Exactly one way serves every access being resolved.
   a_one_way_selected: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot(sel_vec))
      else $error("access resolved without exactly one selected way");

   // Exactly one way holds the most recent rank at all times.
   a_single_mru: assert property (@(posedge clock) disable iff (reset)
      $onehot(mru_vec))
      else $error("recency ranks no longer form a permutation");

   // Every accepted beat gives one response beat, after the busy flag and then the strobe register.
   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response beat missing after request beat");

   // Response beats never come back to back.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // A writeback is only ever reported for a miss.
   a_wb_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_writeback) |-> rsp_fill)
      else $error("writeback reported on a hit");
`endif

endmodule

// File: dv/cache_set_lru_writeback_core_test.sv
// Self-checking testbench for the cache set controller with LRU replacement and write-back.
`timescale 1ns / 1ps

module cache_set_lru_writeback_core_test;
   import csl_pkg::*;

   localparam int NUM_WAYS   = WAYS_DEF;
   localparam int TAG_W      = TAG_PORT_W;
   localparam int RANDOM_ITEMS = 1200;

   // One response beat as the block reports it.
   typedef struct packed {
      logic                  hit;
      logic [WAY_PORT_W-1:0] way;
      logic                  fill;
      logic                  writeback;
      logic [TAG_W-1:0]      victim_tag;
      logic [CNT_W-1:0]      access_count;
      logic [CNT_W-1:0]      hit_count;
      logic [CNT_W-1:0]      miss_count;
      logic [CNT_W-1:0]      writeback_count;
   } access_outcome_type;

   // Tracks the contents and recency order of the set and checks each response.
   class lru_set_tracker_type;
      logic [TAG_W-1:0]   tag_of[NUM_WAYS];
      bit                 valid_of[NUM_WAYS];
      bit                 dirty_of[NUM_WAYS];
      int unsigned        rank_of[NUM_WAYS];
      logic [CNT_W-1:0]   n_access, n_hit, n_miss, n_dirty_evict;
      access_outcome_type awaited[$];
      int unsigned        failures;

      function new();
         for (int i = 0; i < NUM_WAYS; i++) begin
            tag_of[i]   = '0;
            valid_of[i] = 1'b0;
            dirty_of[i] = 1'b0;
            rank_of[i]  = i;
         end
         n_access      = '0;
         n_hit         = '0;
         n_miss        = '0;
         n_dirty_evict = '0;
         failures      = 0;
      endfunction

      // Counters stick at their maximum.
      function logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // Works out the response to an accepted access and updates the set.
      function void note_access(logic op, logic [TAG_W-1:0] tag);
         access_outcome_type r;
         int                 w;
         bit                 found;
         int unsigned        old_rank;
         r     = '0;
         w     = 0;
         found = 1'b0;

         // Look for the tag in a valid way; the lowest match wins.
         for (int i = 0; i < NUM_WAYS; i++) begin
            if (!found && valid_of[i] && tag_of[i] == tag) begin
               found = 1'b1;
               w     = i;
            end
         end

         n_access = sat_bump(n_access);
         if (found) begin
            n_hit = sat_bump(n_hit);
            r.hit = 1'b1;
         end else begin
            n_miss = sat_bump(n_miss);
            r.fill = 1'b1;
            // Prefer the lowest free way, otherwise evict the least recent one.
            for (int i = 0; i < NUM_WAYS; i++) begin
               if (!found && !valid_of[i]) begin
                  found = 1'b1;
                  w     = i;
               end
            end
            if (!found) begin
               w = 0;
               for (int i = 1; i < NUM_WAYS; i++) begin
                  if (rank_of[i] < rank_of[w]) w = i;
               end
               if (dirty_of[w]) begin
                  r.writeback   = 1'b1;
                  r.victim_tag  = tag_of[w];
                  n_dirty_evict = sat_bump(n_dirty_evict);
               end
            end
            tag_of[w]   = tag;
            valid_of[w] = 1'b1;
            dirty_of[w] = 1'b0;
         end

         if (op == OP_WRITE) dirty_of[w] = 1'b1;

         // The used way becomes most recent; more recent ways move down one.
         old_rank = rank_of[w];
         for (int i = 0; i < NUM_WAYS; i++) begin
            if (rank_of[i] > old_rank) rank_of[i]--;
         end
         rank_of[w] = NUM_WAYS - 1;

         r.way             = w[WAY_PORT_W-1:0];
         r.access_count    = n_access;
         r.hit_count       = n_hit;
         r.miss_count      = n_miss;
         r.writeback_count = n_dirty_evict;
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] seen);
         if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            failures++;
         end
      endfunction

      // Compares a response beat with the oldest outstanding prediction.
      function void check_response(access_outcome_type got);
         access_outcome_type want;
         if (awaited.size() == 0) begin
            $error("response beat arrived with no access outstanding");
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare_field("hit", CNT_W'(want.hit), CNT_W'(got.hit));
         compare_field("way", CNT_W'(want.way), CNT_W'(got.way));
         compare_field("fill", CNT_W'(want.fill), CNT_W'(got.fill));
         compare_field("writeback", CNT_W'(want.writeback), CNT_W'(got.writeback));
         compare_field("victim_tag", CNT_W'(want.victim_tag), CNT_W'(got.victim_tag));
         compare_field("access_count", want.access_count, got.access_count);
         compare_field("hit_count", want.hit_count, got.hit_count);
         compare_field("miss_count", want.miss_count, got.miss_count);
         compare_field("writeback_count", want.writeback_count, got.writeback_count);
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    start      = 1'b0;
   logic                    req_op     = OP_READ;
   logic [TAG_W-1:0]        req_tag    = '0;
   logic                    busy;
   logic                    rsp_strobe;
   logic                    rsp_hit;
   logic [WAY_PORT_W-1:0]   rsp_way;
   logic                    rsp_fill;
   logic                    rsp_writeback;
   logic [TAG_W-1:0]        rsp_victim_tag;
   logic [CNT_W-1:0]        rsp_access_count;
   logic [CNT_W-1:0]        rsp_hit_count;
   logic [CNT_W-1:0]        rsp_miss_count;
   logic [CNT_W-1:0]        rsp_writeback_count;

   lru_set_tracker_type board = new();
   bit                  gaps_on = 1'b1;
   int unsigned         random_sent = 0;

   cache_set_lru_writeback_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_tag             (req_tag),
      .rsp_strobe          (rsp_strobe),
      .rsp_hit             (rsp_hit),
      .rsp_way             (rsp_way),
      .rsp_fill            (rsp_fill),
      .rsp_writeback       (rsp_writeback),
      .rsp_victim_tag      (rsp_victim_tag),
      .rsp_access_count    (rsp_access_count),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_miss_count      (rsp_miss_count),
      .rsp_writeback_count (rsp_writeback_count)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Request beats are noted before response beats so that ordering within an edge is fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_access(req_op, req_tag);
         if (rsp_strobe) begin
            board.check_response('{hit: rsp_hit, way: rsp_way, fill: rsp_fill,
                                   writeback: rsp_writeback, victim_tag: rsp_victim_tag,
                                   access_count: rsp_access_count,
                                   hit_count: rsp_hit_count,
                                   miss_count: rsp_miss_count,
                                   writeback_count: rsp_writeback_count});
         end
      end
   end

   // Presents one access, holds it until taken, then, when gaps are on, idles at random.
   task automatic send_access(input logic op, input logic [TAG_W-1:0] tag);
      start   <= 1'b1;
      req_op  <= op;
      req_tag <= tag;
      do @(posedge clock); while (busy !== 1'b0);
      if (gaps_on) begin
         while ($urandom_range(99) < 37) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Tags biased towards the extremes and single-bit patterns.
   function automatic logic [TAG_W-1:0] pick_tag();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return {{(TAG_W-1){1'b0}}, 1'b1} << $urandom_range(TAG_W - 1);
         3: return ~({{(TAG_W-1){1'b0}}, 1'b1} << $urandom_range(TAG_W - 1));
         default: return TAG_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [TAG_W-1:0] pool[10];
      int unsigned      pool_size;
      int unsigned      burst_len;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a zero tag must miss on an empty set, then fills, a dirty fill,
      // clean and dirty evictions, a write hit and hits on every way.
      send_access(OP_READ, 20'h00000);
      send_access(OP_READ, 20'h00000);
      send_access(OP_WRITE, 20'hFFFFF);
      send_access(OP_READ, 20'h00001);
      send_access(OP_READ, 20'h00002);
      send_access(OP_READ, 20'h80000);
      send_access(OP_WRITE, 20'h40000);
      send_access(OP_WRITE, 20'h00001);
      send_access(OP_READ, 20'h12345);
      send_access(OP_READ, 20'hABCDE);
      send_access(OP_READ, 20'h54321);
      send_access(OP_READ, 20'hABCDE);
      send_access(OP_WRITE, 20'h12345);
      send_access(OP_READ, 20'h00001);
      send_access(OP_WRITE, 20'h54321);
      send_access(OP_READ, 20'h7FFFF);
      send_access(OP_READ, 20'hFFFFE);
      send_access(OP_WRITE, 20'h00000);

      // Random: bursts over small tag pools so hits, fills and evictions all occur,
      // with some stray tags mixed in and a long stretch without gaps.
      while (random_sent < RANDOM_ITEMS) begin
         pool_size = $urandom_range(2, 9);
         for (int i = 0; i < pool_size; i++) pool[i] = pick_tag();
         burst_len = $urandom_range(10, 60);
         repeat (burst_len) begin
            gaps_on = !(random_sent >= 500 && random_sent < 700);
            if ($urandom_range(9) == 0)
               send_access(1'($urandom_range(1)), pick_tag());
            else
               send_access(1'($urandom_range(1)), pool[$urandom_range(pool_size - 1)]);
            random_sent++;
         end
      end
      start <= 1'b0;

      // Drain outstanding responses, then allow a few cycles for strays.
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d accesses: %0d hits, %0d misses, %0d dirty evictions.",
               board.n_access, board.n_hit, board.n_miss, board.n_dirty_evict);
      if (board.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Run stopped by the watchdog before the responses drained.");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
